/* hw/rtl/dtp_pkg.sv */
// ----------------------------------------------------------------------------
// Duration text parser package
// Shared types, codes and character constants for the duration parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

   localparam int unsigned VALUE_WIDTH_DEF = 32;
   localparam int unsigned FIELD_WIDTH     = 32;

   typedef logic [FIELD_WIDTH-1:0] field_type;
   typedef logic [7:0]             char_type;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_NEED_P = 2'd1,
      PH_BODY   = 2'd2,
      PH_ERROR  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MISSING_P = 3'd1,
      ERR_ORDER     = 3'd2,
      ERR_MISSING   = 3'd3,
      ERR_BAD_CHAR  = 3'd4,
      ERR_OVERFLOW  = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      STY_NONE      = 3'd0,
      STY_WEEK      = 3'd1,
      STY_DATE      = 3'd2,
      STY_TIME      = 3'd3,
      STY_DATE_TIME = 3'd4
   } style_type;

   typedef enum logic [1:0] {
      UNIT_NONE = 2'd0,
      UNIT_H    = 2'd1,
      UNIT_M    = 2'd2,
      UNIT_S    = 2'd3
   } unit_type;

   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_P     = 8'h50;
   localparam char_type CH_T     = 8'h54;
   localparam char_type CH_W     = 8'h57;
   localparam char_type CH_D     = 8'h44;
   localparam char_type CH_H     = 8'h48;
   localparam char_type CH_M     = 8'h4D;
   localparam char_type CH_S     = 8'h53;

endpackage

/* hw/rtl/dtp_req_if.sv */
// ----------------------------------------------------------------------------
// Duration parser request channel
// Valid/ready channel carrying one character and its end-of-string flag.
// ----------------------------------------------------------------------------
interface dtp_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);

endinterface

/* hw/rtl/dtp_rsp_if.sv */
// ----------------------------------------------------------------------------
// Duration parser response channel
// Valid/ready channel carrying one parsed duration with its error code.
// ----------------------------------------------------------------------------
interface dtp_rsp_if;

   logic        valid;
   logic        ready;
   logic [2:0]  error_code;
   logic        is_negative;
   logic [2:0]  style;
   logic [31:0] weeks;
   logic [31:0] days;
   logic [31:0] hours;
   logic [31:0] minutes;
   logic [31:0] seconds;

   modport source (output valid, output error_code, output is_negative, output style,
                   output weeks, output days, output hours, output minutes,
                   output seconds, input ready);
   modport sink   (input valid, input error_code, input is_negative, input style,
                   input weeks, input days, input hours, input minutes,
                   input seconds, output ready);

endinterface

/* hw/rtl/dtp_acc.sv */
// ----------------------------------------------------------------------------
// Decimal accumulator step
// Computes acc * 10 + digit with shifts and flags a result beyond the width.
// ----------------------------------------------------------------------------
module dtp_acc #(
   parameter int unsigned VALUE_WIDTH = dtp_pkg::VALUE_WIDTH_DEF
) (
   input  logic [VALUE_WIDTH-1:0] acc_value,
   input  logic [3:0]             digit,
   output logic [VALUE_WIDTH-1:0] next_value,
   output logic                   overflow
);

   localparam int unsigned ExtW = VALUE_WIDTH + 4;

   logic [ExtW-1:0] ext;
   logic [ExtW-1:0] prod;

   // 10 * MAX + 9 fits in four extra bits, so the top nibble flags overflow
   assign ext        = {4'b0000, acc_value};
   assign prod       = (ext << 3) + (ext << 1) + {{VALUE_WIDTH{1'b0}}, digit};
   assign overflow   = |prod[ExtW-1:VALUE_WIDTH];
   assign next_value = prod[VALUE_WIDTH-1:0];

endmodule

/* hw/rtl/duration_text_parser.sv */
// ----------------------------------------------------------------------------
// Duration text parser
// Streaming parser for signed week/day/time duration strings, one character
// per transfer; gives one result per string on its final character.
// ----------------------------------------------------------------------------
// The final character goes from the input register to the result register.
// Throughput: 1 character per cycle, bar a final one held by a stall; the
// only loop is the per-character state update between the input register
// and the parser state. A stalled response holds one character there.
// Reset (synchronous) returns the parser to expect a sign or 'P', all zero.
module duration_text_parser #(
   parameter int unsigned VALUE_WIDTH = dtp_pkg::VALUE_WIDTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   dtp_req_if.sink   req_ch,
   dtp_rsp_if.source rsp_ch
);

   // input register
   logic              s1_valid_ff;
   dtp_pkg::char_type s1_char_ff;
   logic              s1_last_ff;

   // parser state
   dtp_pkg::phase_type phase_ff,   phase_in,   phase_step;
   logic               neg_ff,     neg_in,     neg_step;
   dtp_pkg::style_type style_ff,   style_in,   style_step;
   dtp_pkg::unit_type  to_unit_ff, to_unit_in, to_unit_step;
   logic               have_ff,    have_in,    have_step;
   dtp_pkg::err_type   error_ff,   error_in,   error_step;
   logic [VALUE_WIDTH-1:0] acc_ff,    acc_in,    acc_step;
   logic [VALUE_WIDTH-1:0] week_ff,   week_in,   week_step;
   logic [VALUE_WIDTH-1:0] day_ff,    day_in,    day_step;
   logic [VALUE_WIDTH-1:0] hour_ff,   hour_in,   hour_step;
   logic [VALUE_WIDTH-1:0] minute_ff, minute_in, minute_step;
   logic [VALUE_WIDTH-1:0] second_ff, second_in, second_step;

   // result register
   logic               rsp_valid_ff;
   dtp_pkg::err_type   rsp_error_ff;
   logic               rsp_neg_ff;
   dtp_pkg::style_type rsp_style_ff;
   dtp_pkg::field_type rsp_weeks_ff, rsp_days_ff, rsp_hours_ff;
   dtp_pkg::field_type rsp_minutes_ff, rsp_seconds_ff;

   logic advance;
   logic proc;
   logic req_xfer;

   logic                   is_digit;
   dtp_pkg::unit_type      char_unit;
   logic [VALUE_WIDTH-1:0] acc_next;
   logic                   acc_ovf;

   dtp_pkg::err_type char_err;
   logic go_need_p, go_body, set_neg;
   logic act_digit, act_t, act_week, act_day, act_unit, take;
   dtp_pkg::err_type fin_err;

   // ---------------------------------------------------------------- handshake
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   // only the final character needs the result register to be free
   assign proc         = s1_valid_ff && (!s1_last_ff || advance);
   assign req_ch.ready = !s1_valid_ff || proc;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (proc) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.last_char;
      end
   end

   // ---------------------------------------------------------------- decode
   assign is_digit = (s1_char_ff >= dtp_pkg::CH_ZERO) && (s1_char_ff <= dtp_pkg::CH_NINE);

   always_comb begin
      case (s1_char_ff)
         dtp_pkg::CH_H: char_unit = dtp_pkg::UNIT_H;
         dtp_pkg::CH_M: char_unit = dtp_pkg::UNIT_M;
         dtp_pkg::CH_S: char_unit = dtp_pkg::UNIT_S;
         default:       char_unit = dtp_pkg::UNIT_NONE;
      endcase
   end

   dtp_acc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_acc (
      .acc_value  (acc_ff),
      .digit      (s1_char_ff[3:0]),
      .next_value (acc_next),
      .overflow   (acc_ovf)
   );

   always_comb begin
      char_err  = dtp_pkg::ERR_NONE;
      go_need_p = 1'b0;
      go_body   = 1'b0;
      set_neg   = 1'b0;
      act_digit = 1'b0;
      act_t     = 1'b0;
      act_week  = 1'b0;
      act_day   = 1'b0;
      act_unit  = 1'b0;
      case (phase_ff)
         dtp_pkg::PH_START: begin
            if (s1_char_ff == dtp_pkg::CH_PLUS) begin
               go_need_p = 1'b1;
            end else if (s1_char_ff == dtp_pkg::CH_MINUS) begin
               go_need_p = 1'b1;
               set_neg   = 1'b1;
            end else if (s1_char_ff == dtp_pkg::CH_P) begin
               go_body = 1'b1;
            end else begin
               char_err = dtp_pkg::ERR_MISSING_P;
            end
         end
         dtp_pkg::PH_NEED_P: begin
            if (s1_char_ff == dtp_pkg::CH_P) begin
               go_body = 1'b1;
            end else begin
               char_err = dtp_pkg::ERR_MISSING_P;
            end
         end
         dtp_pkg::PH_BODY: begin
            if (is_digit) begin
               if (acc_ovf) char_err = dtp_pkg::ERR_OVERFLOW;
               else         act_digit = 1'b1;
            end else if (s1_char_ff == dtp_pkg::CH_T) begin
               if (have_ff) begin
                  char_err = dtp_pkg::ERR_MISSING;
               end else if (style_ff == dtp_pkg::STY_NONE || style_ff == dtp_pkg::STY_DATE) begin
                  act_t = 1'b1;
               end else begin
                  char_err = dtp_pkg::ERR_ORDER;
               end
            end else if (s1_char_ff == dtp_pkg::CH_W || s1_char_ff == dtp_pkg::CH_D) begin
               if (!have_ff) begin
                  char_err = dtp_pkg::ERR_MISSING;
               end else if (style_ff != dtp_pkg::STY_NONE) begin
                  char_err = dtp_pkg::ERR_ORDER;
               end else if (s1_char_ff == dtp_pkg::CH_W) begin
                  act_week = 1'b1;
               end else begin
                  act_day = 1'b1;
               end
            end else if (char_unit != dtp_pkg::UNIT_NONE) begin
               if (!have_ff) begin
                  char_err = dtp_pkg::ERR_MISSING;
               end else if (style_ff != dtp_pkg::STY_TIME &&
                            style_ff != dtp_pkg::STY_DATE_TIME) begin
                  char_err = dtp_pkg::ERR_ORDER;
               end else if (to_unit_ff != dtp_pkg::UNIT_NONE &&
                            char_unit != dtp_pkg::unit_type'(to_unit_ff + 2'd1)) begin
                  // units must follow on directly; wraps past seconds to none
                  char_err = dtp_pkg::ERR_ORDER;
               end else begin
                  act_unit = 1'b1;
               end
            end else begin
               char_err = dtp_pkg::ERR_BAD_CHAR;
            end
         end
         default: begin
         end
      endcase
   end

   assign take = act_week || act_day || act_unit;

   // ---------------------------------------------------------------- next state
   always_comb begin
      if (char_err != dtp_pkg::ERR_NONE) begin
         phase_step = dtp_pkg::PH_ERROR;
      end else if (go_need_p) begin
         phase_step = dtp_pkg::PH_NEED_P;
      end else if (go_body) begin
         phase_step = dtp_pkg::PH_BODY;
      end else begin
         phase_step = phase_ff;
      end
      if (!proc) begin
         phase_in = phase_ff;
      end else if (s1_last_ff) begin
         phase_in = dtp_pkg::PH_START;
      end else begin
         phase_in = phase_step;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      neg_step = neg_ff || set_neg;
      if (act_t) begin
         style_step = (style_ff == dtp_pkg::STY_NONE) ? dtp_pkg::STY_TIME
                                                     : dtp_pkg::STY_DATE_TIME;
      end else if (act_week) begin
         style_step = dtp_pkg::STY_WEEK;
      end else if (act_day) begin
         style_step = dtp_pkg::STY_DATE;
      end else begin
         style_step = style_ff;
      end
      to_unit_step = act_unit ? char_unit : to_unit_ff;
      if (act_digit)  acc_step = acc_next;
      else if (take)  acc_step = '0;
      else            acc_step = acc_ff;
      if (act_digit)  have_step = 1'b1;
      else if (take)  have_step = 1'b0;
      else            have_step = have_ff;
      week_step   = act_week ? acc_ff : week_ff;
      day_step    = act_day  ? acc_ff : day_ff;
      hour_step   = (act_unit && char_unit == dtp_pkg::UNIT_H) ? acc_ff : hour_ff;
      minute_step = (act_unit && char_unit == dtp_pkg::UNIT_M) ? acc_ff : minute_ff;
      second_step = (act_unit && char_unit == dtp_pkg::UNIT_S) ? acc_ff : second_ff;
      // first error wins
      error_step  = (error_ff == dtp_pkg::ERR_NONE) ? char_err : error_ff;

      // end-of-string checks on the state after this character
      if (error_step != dtp_pkg::ERR_NONE) begin
         fin_err = error_step;
      end else if (phase_step == dtp_pkg::PH_START || phase_step == dtp_pkg::PH_NEED_P) begin
         fin_err = dtp_pkg::ERR_MISSING_P;
      end else if (phase_step == dtp_pkg::PH_BODY &&
                   (have_step || style_step == dtp_pkg::STY_NONE ||
                    ((style_step == dtp_pkg::STY_TIME ||
                      style_step == dtp_pkg::STY_DATE_TIME) &&
                     to_unit_step == dtp_pkg::UNIT_NONE))) begin
         fin_err = dtp_pkg::ERR_MISSING;
      end else begin
         fin_err = dtp_pkg::ERR_NONE;
      end

      if (proc && s1_last_ff) begin
         neg_in     = 1'b0;
         style_in   = dtp_pkg::STY_NONE;
         to_unit_in = dtp_pkg::UNIT_NONE;
         have_in    = 1'b0;
         error_in   = dtp_pkg::ERR_NONE;
         acc_in     = '0;
         week_in    = '0;
         day_in     = '0;
         hour_in    = '0;
         minute_in  = '0;
         second_in  = '0;
      end else if (proc) begin
         neg_in     = neg_step;
         style_in   = style_step;
         to_unit_in = to_unit_step;
         have_in    = have_step;
         error_in   = error_step;
         acc_in     = acc_step;
         week_in    = week_step;
         day_in     = day_step;
         hour_in    = hour_step;
         minute_in  = minute_step;
         second_in  = second_step;
      end else begin
         neg_in     = neg_ff;
         style_in   = style_ff;
         to_unit_in = to_unit_ff;
         have_in    = have_ff;
         error_in   = error_ff;
         acc_in     = acc_ff;
         week_in    = week_ff;
         day_in     = day_ff;
         hour_in    = hour_ff;
         minute_in  = minute_ff;
         second_in  = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dtp_pkg::PH_START;
         neg_ff     <= 1'b0;
         style_ff   <= dtp_pkg::STY_NONE;
         to_unit_ff <= dtp_pkg::UNIT_NONE;
         have_ff    <= 1'b0;
         error_ff   <= dtp_pkg::ERR_NONE;
         acc_ff     <= '0;
         week_ff    <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         style_ff   <= style_in;
         to_unit_ff <= to_unit_in;
         have_ff    <= have_in;
         error_ff   <= error_in;
         acc_ff     <= acc_in;
         week_ff    <= week_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && s1_last_ff) begin
         rsp_error_ff <= fin_err;
         if (fin_err != dtp_pkg::ERR_NONE) begin
            rsp_neg_ff     <= 1'b0;
            rsp_style_ff   <= dtp_pkg::STY_NONE;
            rsp_weeks_ff   <= '0;
            rsp_days_ff    <= '0;
            rsp_hours_ff   <= '0;
            rsp_minutes_ff <= '0;
            rsp_seconds_ff <= '0;
         end else begin
            rsp_neg_ff     <= neg_step;
            rsp_style_ff   <= style_step;
            rsp_weeks_ff   <= dtp_pkg::field_type'(week_step);
            rsp_days_ff    <= dtp_pkg::field_type'(day_step);
            rsp_hours_ff   <= dtp_pkg::field_type'(hour_step);
            rsp_minutes_ff <= dtp_pkg::field_type'(minute_step);
            rsp_seconds_ff <= dtp_pkg::field_type'(second_step);
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.error_code  = rsp_error_ff;
   assign rsp_ch.is_negative = rsp_neg_ff;
   assign rsp_ch.style       = rsp_style_ff;
   assign rsp_ch.weeks       = rsp_weeks_ff;
   assign rsp_ch.days        = rsp_days_ff;
   assign rsp_ch.hours       = rsp_hours_ff;
   assign rsp_ch.minutes     = rsp_minutes_ff;
   assign rsp_ch.seconds     = rsp_seconds_ff;

   // ---------------------------------------------------------------- checks
   a_phase_err_match: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dtp_pkg::PH_ERROR) == (error_ff != dtp_pkg::ERR_NONE))
      else $error("error phase and stored error code disagree");

   a_err_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff != dtp_pkg::ERR_NONE) |->
         (!rsp_neg_ff && rsp_style_ff == dtp_pkg::STY_NONE && rsp_weeks_ff == '0 &&
          rsp_days_ff == '0 && rsp_hours_ff == '0))
      else $error("error result carries non-zero fields");

   a_ok_has_style: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff == dtp_pkg::ERR_NONE) |->
         rsp_style_ff != dtp_pkg::STY_NONE)
      else $error("good result without a style");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (proc && s1_last_ff) |=>
         (phase_ff == dtp_pkg::PH_START && acc_ff == '0 && !have_ff && rsp_valid_ff))
      else $error("final character did not clear state and post a result");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duration text parser testbench
// Streams duration strings into the parser one character per transfer, with
// bursty sending and a patterned response stall. Each accepted character goes
// through a local parse model; every response is checked field by field
// against the oldest predicted duration.
// ----------------------------------------------------------------------------
module tb;
   import dtp_pkg::*;

   localparam int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF;
   localparam logic [63:0] VALUE_MAX    = (VALUE_WIDTH >= 64) ? '1 :
                                          ((64'd1 << VALUE_WIDTH) - 64'd1);
   localparam int          RANDOM_CHARS = 1700;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 16;

   typedef logic [63:0] value_type;

   typedef struct packed {
      err_type   error_code;
      logic      is_negative;
      style_type style;
      field_type weeks;
      field_type days;
      field_type hours;
      field_type minutes;
      field_type seconds;
   } duration_type;

   typedef struct {
      char_type code;
      logic     last;
      bit       hold;
   } char_item_type;

   logic clock = 1'b0;
   logic reset;

   dtp_req_if req_ch ();
   dtp_rsp_if rsp_ch ();

   duration_text_parser #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_item_type pending_chars[$];
   duration_type  durations_due[$];
   char_type      text_buf[$];
   int            total_chars    = 0;
   int            chars_accepted = 0;
   int            fail_count     = 0;
   int            cycle_count    = 0;

   // parse model state
   phase_type parse_phase;
   logic      parse_negative;
   style_type parse_style;
   unit_type  parse_first_unit;
   unit_type  parse_last_unit;
   value_type parse_number;
   logic      parse_digits;
   value_type parse_weeks, parse_days, parse_hours, parse_minutes, parse_seconds;
   err_type   parse_error;

   task automatic clear_parser();
      parse_phase      = PH_START;
      parse_negative   = 1'b0;
      parse_style      = STY_NONE;
      parse_first_unit = UNIT_NONE;
      parse_last_unit  = UNIT_NONE;
      parse_number     = '0;
      parse_digits     = 1'b0;
      parse_weeks      = '0;
      parse_days       = '0;
      parse_hours      = '0;
      parse_minutes    = '0;
      parse_seconds    = '0;
      parse_error      = ERR_NONE;
   endtask

   task automatic flag_error(input err_type code);
      if (parse_error == ERR_NONE) begin
         parse_error = code;
      end
      parse_phase = PH_ERROR;
   endtask

   task automatic parse_body(input char_type c);
      value_type digit;
      unit_type  u;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         digit = 64'(c - CH_ZERO);
         if (parse_number > (VALUE_MAX - digit) / 64'd10) begin
            flag_error(ERR_OVERFLOW);
         end else begin
            parse_number = parse_number * 64'd10 + digit;
            parse_digits = 1'b1;
         end
      end else if (c == CH_T) begin
         if (parse_digits) begin
            flag_error(ERR_MISSING);
         end else if (parse_style == STY_NONE) begin
            parse_style = STY_TIME;
         end else if (parse_style == STY_DATE) begin
            parse_style = STY_DATE_TIME;
         end else begin
            flag_error(ERR_ORDER);
         end
      end else if (c == CH_W || c == CH_D) begin
         if (!parse_digits) begin
            flag_error(ERR_MISSING);
         end else if (parse_style != STY_NONE) begin
            flag_error(ERR_ORDER);
         end else begin
            if (c == CH_W) begin
               parse_weeks = parse_number;
               parse_style = STY_WEEK;
            end else begin
               parse_days  = parse_number;
               parse_style = STY_DATE;
            end
            parse_number = '0;
            parse_digits = 1'b0;
         end
      end else if (c == CH_H || c == CH_M || c == CH_S) begin
         u = (c == CH_H) ? UNIT_H : (c == CH_M) ? UNIT_M : UNIT_S;
         if (!parse_digits) begin
            flag_error(ERR_MISSING);
         end else if (parse_style != STY_TIME && parse_style != STY_DATE_TIME) begin
            flag_error(ERR_ORDER);
         end else if (parse_last_unit != UNIT_NONE && u != parse_last_unit + 1) begin
            flag_error(ERR_ORDER);
         end else begin
            case (u)
               UNIT_H:  parse_hours   = parse_number;
               UNIT_M:  parse_minutes = parse_number;
               default: parse_seconds = parse_number;
            endcase
            parse_number = '0;
            parse_digits = 1'b0;
            if (parse_first_unit == UNIT_NONE) begin
               parse_first_unit = u;
            end
            parse_last_unit = u;
         end
      end else begin
         flag_error(ERR_BAD_CHAR);
      end
   endtask

   // advance the model by one character; the final one yields a duration
   task automatic parse_char(input char_type c, input logic last);
      duration_type res;
      case (parse_phase)
         PH_START: begin
            if (c == CH_PLUS) begin
               parse_phase = PH_NEED_P;
            end else if (c == CH_MINUS) begin
               parse_negative = 1'b1;
               parse_phase    = PH_NEED_P;
            end else if (c == CH_P) begin
               parse_phase = PH_BODY;
            end else begin
               flag_error(ERR_MISSING_P);
            end
         end
         PH_NEED_P: begin
            if (c == CH_P) begin
               parse_phase = PH_BODY;
            end else begin
               flag_error(ERR_MISSING_P);
            end
         end
         PH_BODY: parse_body(c);
         default: ;
      endcase
      if (last) begin
         if (parse_phase == PH_START || parse_phase == PH_NEED_P) begin
            flag_error(ERR_MISSING_P);
         end else if (parse_phase == PH_BODY) begin
            if (parse_digits || parse_style == STY_NONE ||
                ((parse_style == STY_TIME || parse_style == STY_DATE_TIME) &&
                 parse_last_unit == UNIT_NONE)) begin
               flag_error(ERR_MISSING);
            end
         end
         res = '0;
         res.error_code = parse_error;
         if (parse_error == ERR_NONE) begin
            res.is_negative = parse_negative;
            res.style       = parse_style;
            res.weeks       = parse_weeks[FIELD_WIDTH-1:0];
            res.days        = parse_days[FIELD_WIDTH-1:0];
            res.hours       = parse_hours[FIELD_WIDTH-1:0];
            res.minutes     = parse_minutes[FIELD_WIDTH-1:0];
            res.seconds     = parse_seconds[FIELD_WIDTH-1:0];
         end
         durations_due.push_back(res);
         clear_parser();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ---- stimulus construction -------------------------------------------

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   task automatic append_number();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: append_text($sformatf("%0d", $urandom_range(0, 99)));
         4: append_text($sformatf("%0d", $urandom_range(0, 99999)));
         5: append_text($sformatf("%0d", $urandom));
         // straddles the 32-bit limit
         6: append_text($sformatf("%0d", 64'd4294967290 + 64'($urandom_range(0, 9))));
         7: append_text($sformatf("00%0d", $urandom_range(0, 999)));
         8: begin
            n = $urandom_range(11, 14);
            repeat (n) text_buf.push_back(CH_ZERO + char_type'($urandom_range(0, 9)));
         end
         default: text_buf.push_back(CH_ZERO);
      endcase
   endtask

   task automatic build_wellformed();
      int sel;
      int first_u;
      int last_u;
      text_buf.delete();
      case ($urandom_range(0, 2))
         1: text_buf.push_back(CH_PLUS);
         2: text_buf.push_back(CH_MINUS);
         default: ;
      endcase
      text_buf.push_back(CH_P);
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
         append_number();
         text_buf.push_back(CH_W);
      end
      if (sel == 1 || sel == 3) begin
         append_number();
         text_buf.push_back(CH_D);
      end
      if (sel >= 2) begin
         text_buf.push_back(CH_T);
         first_u = $urandom_range(1, 3);
         last_u  = $urandom_range(first_u, 3);
         for (int u = first_u; u <= last_u; u++) begin
            append_number();
            case (u)
               1:       text_buf.push_back(CH_H);
               2:       text_buf.push_back(CH_M);
               default: text_buf.push_back(CH_S);
            endcase
         end
      end
   endtask

   function automatic char_type pick_char();
      string syntax = "PTWDHMS09+- ";
      if ($urandom_range(0, 1) == 1) begin
         return char_type'($urandom_range(0, 255));
      end
      return syntax[$urandom_range(0, syntax.len() - 1)];
   endfunction

   task automatic damage_text();
      int pos;
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 3))
         0: text_buf[pos] = pick_char();
         1: begin
            if (text_buf.size() > 1) begin
               text_buf.delete(pos);
            end else begin
               text_buf[pos] = pick_char();
            end
         end
         2: text_buf.insert(pos, pick_char());
         default: begin
            while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
         end
      endcase
   endtask

   task automatic submit_text(input bit hold);
      char_item_type item;
      foreach (text_buf[i]) begin
         item.code = text_buf[i];
         item.last = (i == text_buf.size() - 1);
         item.hold = hold && (i == 0);
         pending_chars.push_back(item);
      end
      total_chars += text_buf.size();
   endtask

   task automatic directed_text(input string s);
      text_buf.delete();
      append_text(s);
      submit_text(1'b0);
   endtask

   // ---- sender: bursts with random gaps ---------------------------------

   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      char_item_type nxt;
      logic          hold_off;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // a held item waits until every predicted duration has been returned
         hold_off = pending_chars.size() != 0 && pending_chars[0].hold &&
                    (durations_due.size() != 0 || (req_ch.valid && req_ch.last_char));
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_chars.size() == 0 || hold_off) begin
            req_ch.valid <= 1'b0;
         end else begin
            nxt = pending_chars.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.char_code <= nxt.code;
            req_ch.last_char <= nxt.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ---- receiver: rotating stall pattern, reloaded now and then ---------

   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age   = 200;
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                            (16'($urandom) | 16'h0001);
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_ch.ready <= stall_pattern[0];
      end
   end

   // ---- monitor: predict on character transfer, check on result transfer -

   always @(posedge clock) begin
      duration_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            parse_char(req_ch.char_code, req_ch.last_char);
            chars_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (durations_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual error_code %0d",
                        $time, rsp_ch.error_code);
               fail_count++;
            end else begin
               want = durations_due.pop_front();
               check_field("error_code",  32'(want.error_code),  32'(rsp_ch.error_code));
               check_field("is_negative", 32'(want.is_negative), 32'(rsp_ch.is_negative));
               check_field("style",       32'(want.style),       32'(rsp_ch.style));
               check_field("weeks",       want.weeks,            rsp_ch.weeks);
               check_field("days",        want.days,             rsp_ch.days);
               check_field("hours",       want.hours,            rsp_ch.hours);
               check_field("minutes",     want.minutes,          rsp_ch.minutes);
               check_field("seconds",     want.seconds,          rsp_ch.seconds);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int random_chars;
      int text_count;
      int mode;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.last_char = 1'b0;
      rsp_ch.ready     = 1'b0;
      clear_parser();

      // directed: forms, limits and each error class
      directed_text("P1W");
      directed_text("-P2D");
      directed_text("+PT3H");
      directed_text("P4DT5H6M7S");
      directed_text("-P0DT0M59S");
      directed_text("P4294967295W");
      directed_text("P4294967296D");
      directed_text("PT99999999999S");
      directed_text("X1D");
      directed_text("+X");
      directed_text("-");
      directed_text("P");
      directed_text("P12");
      directed_text("PT");
      directed_text("P1DT");
      directed_text("PT1H2S");
      directed_text("PT1M1H");
      directed_text("P1W1D");
      directed_text("P1WT");
      directed_text("PT1HT");
      directed_text("P1H");
      directed_text("PW");
      directed_text("P1T");
      directed_text("P1d");
      directed_text("P-1D");
      text_buf.delete();
      append_text("P");
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      submit_text(1'b0);

      // random: mostly well-formed, some damaged, some noise
      random_chars = 0;
      text_count   = 0;
      while (random_chars < RANDOM_CHARS) begin
         mode = $urandom_range(0, 99);
         if (mode < 70) begin
            build_wellformed();
         end else if (mode < 90) begin
            build_wellformed();
            damage_text();
            if ($urandom_range(0, 1) == 1) damage_text();
         end else begin
            text_buf.delete();
            if ($urandom_range(0, 1) == 1) text_buf.push_back(CH_P);
            repeat ($urandom_range(1, 6)) text_buf.push_back(char_type'($urandom_range(0, 255)));
         end
         random_chars += text_buf.size();
         submit_text(text_count % 60 == 0);
         text_count++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (chars_accepted != total_chars || durations_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/dtp_pkg.sv
hw/rtl/dtp_req_if.sv
hw/rtl/dtp_rsp_if.sv
hw/rtl/dtp_acc.sv
hw/rtl/duration_text_parser.sv
verif/tb.sv
